/* rtl/core/fsnp_pkg.sv */
// ----------------------------------------------------------------------------
// fsnp_pkg
// shared types and constants of the format string number printer
// ----------------------------------------------------------------------------
package fsnp_pkg;

    localparam int CHAR_W        = 8;
    localparam int VAL_W         = 64;
    localparam int DIGIT_W       = 4;
    localparam int DIGIT_DEPTH   = 64;
    localparam int MAX_WIDTH_DEF = 64;

    typedef enum logic [1:0] {
        RADIX_BIN,
        RADIX_OCT,
        RADIX_DEC,
        RADIX_HEX
    } radix_t;

    typedef struct packed {
        logic [CHAR_W-1:0]       fmt_char;
        logic signed [VAL_W-1:0] arg_value;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic               done;
        logic [VAL_W-1:0]   quot;
        logic [DIGIT_W-1:0] rem;
    } div_res_t;

endpackage

/* rtl/core/fsnp_ram.sv */
// ----------------------------------------------------------------------------
// fsnp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fsnp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/fsnp_div.sv */
// ----------------------------------------------------------------------------
// fsnp_div
// shared digit unit: divides a value by the radix, giving quotient and digit
// power-of-two radix by a shift, radix ten four quotient bits per cycle
// ----------------------------------------------------------------------------
module fsnp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  fsnp_pkg::radix_t           radix,
    input  logic [fsnp_pkg::VAL_W-1:0] dividend,
    output fsnp_pkg::div_res_t         res
);

    localparam int VW    = fsnp_pkg::VAL_W;
    localparam int DW    = fsnp_pkg::DIGIT_W;
    localparam int STEPS = VW / 4;
    localparam int SW    = $clog2(STEPS);

    logic [VW-1:0] q_reg;
    logic [DW-1:0] r_reg;
    logic [SW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW-1:0] q_step;
    logic [DW-1:0] r_step;

    always_comb
    begin
        logic [DW:0]   r;
        logic [VW-1:0] q;
        r = {1'b0, r_reg};
        q = q_reg;
        for (int k = 0; k < 4; k++)
        begin
            r = {r[DW-1:0], q[VW-1]};
            q = {q[VW-2:0], (r >= (DW+1)'(10))};
            if (r >= (DW+1)'(10))
            begin
                r = r - (DW+1)'(10);
            end
        end
        q_step = q;
        r_step = r[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            case (radix)
                fsnp_pkg::RADIX_BIN:
                begin
                    q_reg    <= dividend >> 1;
                    r_reg    <= {3'b000, dividend[0]};
                    done_reg <= 1'b1;
                end
                fsnp_pkg::RADIX_OCT:
                begin
                    q_reg    <= dividend >> 3;
                    r_reg    <= {1'b0, dividend[2:0]};
                    done_reg <= 1'b1;
                end
                fsnp_pkg::RADIX_HEX:
                begin
                    q_reg    <= dividend >> 4;
                    r_reg    <= dividend[3:0];
                    done_reg <= 1'b1;
                end
                default:
                begin
                    q_reg    <= dividend;
                    r_reg    <= '0;
                    cnt_reg  <= SW'(STEPS - 1);
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            q_reg   <= q_step;
            r_reg   <= r_step;
            cnt_reg <= cnt_reg - SW'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign res.done = done_reg;
    assign res.quot = q_reg;
    assign res.rem  = r_reg;

endmodule

/* rtl/core/format_string_number_printer.sv */
// ----------------------------------------------------------------------------
// format_string_number_printer
// printf style formatter: takes format bytes with arguments, emits characters
// ----------------------------------------------------------------------------
// Format bytes arrive one per item, each with an argument that a conversion
// byte consumes. Text bytes, unknown specifiers and the terminating NUL give
// one character; directive bytes that do not complete a conversion give none
// and leave the input ready. A number conversion first extracts digits in the
// shared divider, by a shift for b, o, O, x and X and by radix ten division
// for d, D, u and U (radix ten division yields four quotient bits per cycle),
// then passes the length, sign and pad states and emits each digit through a
// read and an emit state and each pad character from a pad state, holding
// while the output stalls. The input is not ready from acceptance of a
// completing byte until its last character is loaded into the output register.
// ----------------------------------------------------------------------------
module format_string_number_printer #(
    parameter int MAX_WIDTH = fsnp_pkg::MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsnp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fsnp_pkg::out_item_t out_data
);

    localparam int FW    = $clog2(MAX_WIDTH + 1);
    localparam int WW    = FW + 4;
    localparam int DEPTH = fsnp_pkg::DIGIT_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CW    = FW > NW ? FW : NW;
    localparam int VW    = fsnp_pkg::VAL_W;
    localparam int DW    = fsnp_pkg::DIGIT_W;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_LO    = 8'h6f;
    localparam logic [7:0] CH_UO    = 8'h4f;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_UU    = 8'h55;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_PCT,
        PH_MINUS,
        PH_ZERO,
        PH_WIDTH,
        PH_PREC,
        PH_SPEC,
        PH_LONG
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DGO,
        S_DWAIT,
        S_LEN,
        S_LSIGN,
        S_LPAD,
        S_MSIGN,
        S_DRD,
        S_DEMIT,
        S_TPAD
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_NUM,
        ACT_CHR,
        ACT_ECHO
    } act_t;

    state_t              state_reg,  state_next;
    phase_t              phase_reg,  phase_next;
    logic                left_reg,   left_next;
    logic                zero_reg,   zero_next;
    logic [FW-1:0]       fw_reg,     fw_next;
    logic                long_reg,   long_next;
    logic [VW-1:0]       val_reg,    val_next;
    fsnp_pkg::radix_t    radix_reg,  radix_next;
    logic                neg_reg,    neg_next;
    logic                upper_reg,  upper_next;
    logic                chrm_reg,   chrm_next;
    logic [7:0]          chr_reg,    chr_next;
    logic [NW-1:0]       n_reg,      n_next;
    logic [NW-1:0]       idx_reg,    idx_next;
    logic [FW-1:0]       cnt_reg,    cnt_next;
    fsnp_pkg::out_item_t out_reg,    out_next;
    logic                ovalid_reg, ovalid_next;

    fsnp_pkg::div_res_t  div_res;
    logic                ram_we;
    logic [DW-1:0]       ram_rdata;
    logic                emit_ok;
    logic                zero_eff;

    function automatic logic [7:0] digit_char(input logic [DW-1:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d <= DW'(9))
        begin
            return CH_ZERO + {4'b0000, d};
        end
        return base + {4'b0000, d} - 8'd10;
    endfunction

    fsnp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DGO),
        .radix    (radix_reg),
        .dividend (val_reg),
        .res      (div_res)
    );

    fsnp_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (n_reg[AW-1:0]),
        .wdata (div_res.rem),
        .raddr (AW'(idx_reg - NW'(1))),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
    assign emit_ok   = !ovalid_reg || out_ready;
    assign zero_eff  = zero_reg && !left_reg && !chrm_reg;

    always_comb
    begin
        logic [7:0]    c;
        logic          dig;
        phase_t        p;
        act_t          act;
        logic [WW-1:0] wsum;
        logic [VW-1:0] lv;
        logic [CW-1:0] len;
        logic [CW-1:0] fwx;
        logic          emit;
        logic [7:0]    ech;
        logic          elast;
        logic          fin;

        state_next  = state_reg;
        phase_next  = phase_reg;
        left_next   = left_reg;
        zero_next   = zero_reg;
        fw_next     = fw_reg;
        long_next   = long_reg;
        val_next    = val_reg;
        radix_next  = radix_reg;
        neg_next    = neg_reg;
        upper_next  = upper_reg;
        chrm_next   = chrm_reg;
        chr_next    = chr_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        ram_we      = 1'b0;
        emit        = 1'b0;
        ech         = CH_SPACE;
        elast       = 1'b0;
        fin         = 1'b0;

        c    = in_data.fmt_char;
        dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        p    = phase_reg;
        act  = ACT_NONE;
        wsum = (WW'(fw_reg) << 3) + (WW'(fw_reg) << 1) + WW'(c[3:0]);
        lv   = long_reg ? VW'(in_data.arg_value)
                        : {{32{in_data.arg_value[31]}}, in_data.arg_value[31:0]};
        len  = CW'(n_reg) + CW'(neg_reg);
        fwx  = CW'(fw_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (c == CH_NUL)
                    begin
                        act = ACT_ECHO;
                    end
                    else if (p == PH_TEXT)
                    begin
                        if (c == CH_PCT)
                        begin
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            act = ACT_ECHO;
                        end
                    end
                    else
                    begin
                        if (p == PH_PCT)
                        begin
                            if (c == CH_MINUS)
                            begin
                                left_next  = 1'b1;
                                phase_next = PH_MINUS;
                                p          = PH_TEXT;
                            end
                            else if (c == CH_ZERO)
                            begin
                                zero_next  = 1'b1;
                                phase_next = PH_ZERO;
                                p          = PH_TEXT;
                            end
                            else
                            begin
                                p = PH_WIDTH;
                            end
                        end
                        else if (p == PH_MINUS)
                        begin
                            if (c == CH_ZERO)
                            begin
                                zero_next  = 1'b1;
                                phase_next = PH_WIDTH;
                                p          = PH_TEXT;
                            end
                            else
                            begin
                                p = PH_WIDTH;
                            end
                        end
                        else if (p == PH_ZERO)
                        begin
                            if (c == CH_MINUS)
                            begin
                                left_next  = 1'b1;
                                phase_next = PH_WIDTH;
                                p          = PH_TEXT;
                            end
                            else
                            begin
                                p = PH_WIDTH;
                            end
                        end

                        if (p == PH_WIDTH)
                        begin
                            if (dig)
                            begin
                                fw_next    = (wsum > WW'(MAX_WIDTH)) ? FW'(MAX_WIDTH)
                                                                     : FW'(wsum);
                                phase_next = PH_WIDTH;
                                p          = PH_TEXT;
                            end
                            else if (c == CH_DOT)
                            begin
                                phase_next = PH_PREC;
                                p          = PH_TEXT;
                            end
                            else
                            begin
                                p = PH_LONG;
                            end
                        end
                        else if (p == PH_PREC)
                        begin
                            if (dig)
                            begin
                                p = PH_TEXT;
                            end
                            else
                            begin
                                p = PH_LONG;
                            end
                        end

                        if (p == PH_LONG && c == CH_L)
                        begin
                            long_next  = 1'b1;
                            phase_next = PH_SPEC;
                        end
                        else if (p != PH_TEXT)
                        begin
                            case (c)
                                CH_LB, CH_LD, CH_UD, CH_LO, CH_UO,
                                CH_LU, CH_UU, CH_LX, CH_UX: act = ACT_NUM;
                                CH_LC:                      act = ACT_CHR;
                                default:                    act = ACT_ECHO;
                            endcase
                        end
                    end

                    case (act)
                        ACT_NUM:
                        begin
                            upper_next = (c == CH_UX);
                            neg_next   = 1'b0;
                            val_next   = lv;
                            case (c)
                                CH_LB:        radix_next = fsnp_pkg::RADIX_BIN;
                                CH_LO, CH_UO: radix_next = fsnp_pkg::RADIX_OCT;
                                CH_LX, CH_UX: radix_next = fsnp_pkg::RADIX_HEX;
                                default:      radix_next = fsnp_pkg::RADIX_DEC;
                            endcase
                            if ((c == CH_LD || c == CH_UD) && lv[VW-1])
                            begin
                                neg_next = 1'b1;
                                val_next = ~lv + VW'(1);
                            end
                            chrm_next  = 1'b0;
                            n_next     = '0;
                            state_next = S_DGO;
                        end
                        ACT_CHR:
                        begin
                            chr_next   = in_data.arg_value[7:0];
                            chrm_next  = 1'b1;
                            neg_next   = 1'b0;
                            n_next     = NW'(1);
                            state_next = S_LEN;
                        end
                        ACT_ECHO:
                        begin
                            chr_next   = c;
                            chrm_next  = 1'b1;
                            neg_next   = 1'b0;
                            left_next  = 1'b0;
                            fw_next    = '0;
                            n_next     = NW'(1);
                            state_next = S_LEN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_DGO:
            begin
                state_next = S_DWAIT;
            end

            S_DWAIT:
            begin
                if (div_res.done)
                begin
                    ram_we   = 1'b1;
                    n_next   = n_reg + NW'(1);
                    val_next = div_res.quot;
                    if (div_res.quot == '0 || n_next == NW'(DEPTH))
                    begin
                        state_next = S_LEN;
                    end
                    else
                    begin
                        state_next = S_DGO;
                    end
                end
            end

            S_LEN:
            begin
                cnt_next   = (fwx > len) ? FW'(fwx - len) : '0;
                idx_next   = n_reg;
                state_next = S_LSIGN;
            end

            S_LSIGN:
            begin
                if (neg_reg && (left_reg || zero_eff))
                begin
                    if (emit_ok)
                    begin
                        emit       = 1'b1;
                        ech        = CH_MINUS;
                        state_next = S_LPAD;
                    end
                end
                else
                begin
                    state_next = S_LPAD;
                end
            end

            S_LPAD:
            begin
                if (left_reg || cnt_reg == '0)
                begin
                    state_next = S_MSIGN;
                end
                else if (emit_ok)
                begin
                    emit     = 1'b1;
                    ech      = zero_eff ? CH_ZERO : CH_SPACE;
                    cnt_next = cnt_reg - FW'(1);
                end
            end

            S_MSIGN:
            begin
                if (neg_reg && !left_reg && !zero_eff)
                begin
                    if (emit_ok)
                    begin
                        emit       = 1'b1;
                        ech        = CH_MINUS;
                        state_next = S_DRD;
                    end
                end
                else
                begin
                    state_next = S_DRD;
                end
            end

            S_DRD:
            begin
                state_next = S_DEMIT;
            end

            S_DEMIT:
            begin
                if (emit_ok)
                begin
                    emit     = 1'b1;
                    ech      = chrm_reg ? chr_reg : digit_char(ram_rdata, upper_reg);
                    elast    = (idx_reg == NW'(1)) && (cnt_reg == '0);
                    idx_next = idx_reg - NW'(1);
                    if (idx_reg == NW'(1))
                    begin
                        if (cnt_reg == '0)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            state_next = S_TPAD;
                        end
                    end
                    else
                    begin
                        state_next = S_DRD;
                    end
                end
            end

            S_TPAD:
            begin
                if (emit_ok)
                begin
                    emit     = 1'b1;
                    ech      = CH_SPACE;
                    elast    = (cnt_reg == FW'(1));
                    cnt_next = cnt_reg - FW'(1);
                    if (cnt_reg == FW'(1))
                    begin
                        fin = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
            phase_next = PH_TEXT;
            left_next  = 1'b0;
            zero_next  = 1'b0;
            fw_next    = '0;
            long_next  = 1'b0;
        end

        ovalid_next = ovalid_reg && !out_ready;
        out_next    = out_reg;
        if (emit)
        begin
            ovalid_next       = 1'b1;
            out_next.out_char = ech;
            out_next.last     = elast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_TEXT;
            left_reg   <= 1'b0;
            zero_reg   <= 1'b0;
            fw_reg     <= '0;
            long_reg   <= 1'b0;
            val_reg    <= '0;
            radix_reg  <= fsnp_pkg::RADIX_DEC;
            neg_reg    <= 1'b0;
            upper_reg  <= 1'b0;
            chrm_reg   <= 1'b0;
            chr_reg    <= '0;
            n_reg      <= '0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            out_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            zero_reg   <= zero_next;
            fw_reg     <= fw_next;
            long_reg   <= long_next;
            val_reg    <= val_next;
            radix_reg  <= radix_next;
            neg_reg    <= neg_next;
            upper_reg  <= upper_next;
            chrm_reg   <= chrm_next;
            chr_reg    <= chr_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            out_reg    <= out_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DWAIT)
        else $error("divider result outside digit wait");

    a_digit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(DEPTH))
        else $error("digit count beyond store depth");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEMIT || state_reg == S_DRD) |-> idx_reg != '0)
        else $error("digit emission with no digit left");

    a_last_clears_directive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_next == S_IDLE)
        |=> (phase_reg == PH_TEXT && fw_reg == '0 && !left_reg && out_reg.last))
        else $error("finished item left directive state or missed last");

    a_width_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        fw_reg <= FW'(MAX_WIDTH))
        else $error("field width above its limit");
`endif

endmodule
